// ===== design/aging_address_conflict_table_core_macros.svh =====
// Assertion macros for the aging address conflict table core.
// Included by the top level; no other dependencies.
`ifndef AGING_ADDRESS_CONFLICT_TABLE_CORE_MACROS_SVH
`define AGING_ADDRESS_CONFLICT_TABLE_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked outside reset
`define AACT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define AACT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define AACT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define AACT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/aact_pkg.sv =====
// Shared types and codes for the aging address conflict table.
// No dependencies; used by the cell and the top level.
package aact_pkg;

  // operation kinds carried by an input word
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // content of one table entry as it moves along the row
  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] ticks;
  } cell_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic        exec;
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] load;
  } cmd_t;

  // flags rippling from the oldest cell toward the newest
  typedef struct packed {
    logic hole;   // a free cell at or before this point
    logic match;  // a matching entry at or before this point
  } chain_t;

endpackage

// ===== design/aact_cell.sv =====
// One table entry of the aging address conflict table.
// Depends on aact_pkg; instantiated in a row by the top level.
module aact_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  aact_pkg::cmd_t   cmd_i,
  input  aact_pkg::chain_t chain_i,
  output aact_pkg::chain_t chain_o,
  input  aact_pkg::cell_t  right_i,
  output aact_pkg::cell_t  cell_o
);
  import aact_pkg::*;

  logic        valid_q, valid_d;
  logic [31:0] addr_q, addr_d;
  logic [15:0] port_q, port_d;
  logic [15:0] ticks_q, ticks_d;
  logic        hit;

  // match and ripple flags
  always_comb begin
    hit           = valid_q && (addr_q == cmd_i.addr) && (port_q == cmd_i.port);
    chain_o.hole  = chain_i.hole | ~valid_q;
    chain_o.match = chain_i.match | hit;
  end

  assign cell_o = '{valid: valid_q, addr: addr_q, port: port_q, ticks: ticks_q};

  // next state: operation when executing, otherwise close gaps by pulling from the right
  always_comb begin
    valid_d = valid_q;
    addr_d  = addr_q;
    port_d  = port_q;
    ticks_d = ticks_q;
    if (!cmd_i.exec) begin
      if (chain_o.hole) begin
        valid_d = right_i.valid;
        addr_d  = right_i.addr;
        port_d  = right_i.port;
        ticks_d = right_i.ticks;
      end
    end else begin
      case (cmd_i.kind)
        KIND_LOOKUP: begin
          // only the oldest match is refreshed
          if (hit && !chain_i.match) ticks_d = cmd_i.load;
        end
        KIND_ADD: begin
          // row is packed, so the first free cell follows all valid ones
          if (!valid_q && !chain_i.hole) begin
            valid_d = 1'b1;
            addr_d  = cmd_i.addr;
            port_d  = cmd_i.port;
            ticks_d = cmd_i.load;
          end
        end
        KIND_TICK: begin
          if (valid_q) begin
            if (ticks_q <= 16'd1) valid_d = 1'b0;
            else ticks_d = ticks_q - 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    port_q  <= port_d;
    ticks_q <= ticks_d;
  end

endmodule

// ===== design/aging_address_conflict_table_core.sv =====
// Aging address conflict table: a row of entry cells kept packed in add order.
// Includes aging_address_conflict_table_core_macros.svh; depends on aact_pkg, aact_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word: kind_i, peer_address_i,
//   peer_port_i. Kind lookup and add each give one result word on the output
//   channel (out_valid_o/out_ready_i, success_o); a tick and the unused kind give none.
//   A word is taken into an operation register, applied to all cells from there,
//   and its result lands in the output register; no new word is taken while one
//   waits in the operation register. After a tick that frees entries, the row
//   closes its gaps by one position per cycle, and in_ready_o stays low meanwhile.
//   Oldest entries sit in cell 0, so the oldest match wins a lookup by position.
//   cfg_we_i writes timeout_ticks at once; write it only while the block is idle.
//   Reset empties the table and sets timeout_ticks to 1000.
//   A stalled receiver holds the result; ticks and the unused kind still go through,
//   and the next lookup or add waits in the operation register until it is taken.
`include "aging_address_conflict_table_core_macros.svh"

module aging_address_conflict_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] peer_address_i,
  input  logic [15:0] peer_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        success_o
);
  import aact_pkg::*;

  logic [15:0] timeout_q;
  logic        op_valid_q;
  logic [1:0]  op_kind_q;
  logic [31:0] op_addr_q;
  logic [15:0] op_port_q;
  logic        out_valid_q;
  logic        success_q;

  logic        accept;
  logic        exec;
  logic        gives_result;
  logic        need_compact;
  cmd_t        cmd;
  chain_t      chain [TABLE_DEPTH+1];
  cell_t       cells [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] valid_vec;

  // timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) timeout_q <= TIMEOUT_RESET;
    else if (cfg_we_i) timeout_q <= cfg_wdata_i;
  end

  // gap detection: a free cell followed by a valid one
  always_comb begin
    need_compact = 1'b0;
    for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
      need_compact = need_compact | (chain[i+1].hole & cells[i+1].valid);
    end
  end

  assign in_ready_o   = !op_valid_q && !need_compact;
  assign accept       = in_valid_i && in_ready_o;
  assign gives_result = (op_kind_q == KIND_LOOKUP) || (op_kind_q == KIND_ADD);
  assign exec         = op_valid_q && (!gives_result || !out_valid_q || out_ready_i);

  // operation register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) op_valid_q <= 1'b0;
    else if (accept) op_valid_q <= 1'b1;
    else if (exec) op_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_kind_q <= kind_i;
      op_addr_q <= peer_address_i;
      op_port_q <= peer_port_i;
    end
  end

  // broadcast to the row
  always_comb begin
    cmd.exec = exec;
    cmd.kind = op_kind_q;
    cmd.addr = op_addr_q;
    cmd.port = op_port_q;
    cmd.load = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
  end

  assign chain[0] = '{hole: 1'b0, match: 1'b0};
  assign cells[TABLE_DEPTH] = '0;

  // row of cells, oldest first
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    aact_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .chain_i (chain[g]),
      .chain_o (chain[g+1]),
      .right_i (cells[g+1]),
      .cell_o  (cells[g])
    );
    assign valid_vec[g] = cells[g].valid;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (exec && gives_result) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (exec && gives_result) begin
      success_q <= (op_kind_q == KIND_LOOKUP) ? chain[TABLE_DEPTH].match
                                              : chain[TABLE_DEPTH].hole;
    end
  end

  assign out_valid_o = out_valid_q;
  assign success_o   = success_q;

  // checks
  `AACT_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, exec && gives_result, out_valid_q)
  `AACT_ASSERT_NEXT(a_add_grows, clk_i, rst_ni,
    exec && (op_kind_q == KIND_ADD) && chain[TABLE_DEPTH].hole,
    $countones(valid_vec) == $past($countones(valid_vec)) + 1)
  `AACT_ASSERT_NEXT(a_tick_shrinks, clk_i, rst_ni, exec && (op_kind_q == KIND_TICK),
    $countones(valid_vec) <= $past($countones(valid_vec)))
  `AACT_ASSERT_NEXT(a_compact_keeps, clk_i, rst_ni, need_compact && !exec,
    $countones(valid_vec) == $past($countones(valid_vec)))

endmodule
